[src/gdc_pkg.sv]
// shared types, command codes and calendar tables for the gregorian date converter
`timescale 1ns / 1ps

package gdc_pkg;

    // command codes
    localparam logic [1:0] CMD_DATE_TO_DOY = 2'd0;
    localparam logic [1:0] CMD_ORD_TO_DATE = 2'd1;
    localparam logic [1:0] CMD_SER_TO_DATE = 2'd2;

    // internal year counter width, covers the full parameter range
    localparam int YEAR_W = 16;

    // year lengths
    localparam logic [8:0] DAYS_LEAP   = 9'd366;
    localparam logic [8:0] DAYS_COMMON = 9'd365;

    // input word
    typedef struct packed {
        logic [1:0]  command;
        logic [13:0] year;
        logic [3:0]  month;
        logic [4:0]  day;
        logic [21:0] day_number;
    } t_in_word;

    // result word
    typedef struct packed {
        logic [13:0] out_year;
        logic [3:0]  out_month;
        logic [4:0]  out_day;
        logic [8:0]  day_of_year;
        logic        status;
    } t_out_word;

    // controller to datapath commands
    typedef struct packed {
        logic load;
        logic year_step;
        logic month_enter;
        logic month_step;
        logic emit;
    } t_ctrl_cmd;

    // datapath to controller status
    typedef struct packed {
        logic in_ok;
        logic year_done;
        logic month_done;
    } t_dp_status;

    // month length, month given 1..12
    function automatic logic [4:0] month_len(input logic [3:0] m, input logic leap);
        logic [4:0] n;
        case (m)
            4'd1:    n = 5'd31;
            4'd2:    n = leap ? 5'd29 : 5'd28;
            4'd3:    n = 5'd31;
            4'd4:    n = 5'd30;
            4'd5:    n = 5'd31;
            4'd6:    n = 5'd30;
            4'd7:    n = 5'd31;
            4'd8:    n = 5'd31;
            4'd9:    n = 5'd30;
            4'd10:   n = 5'd31;
            4'd11:   n = 5'd30;
            4'd12:   n = 5'd31;
            default: n = 5'd31;
        endcase
        return n;
    endfunction

endpackage

[src/gregorian_date_converter_unit.sv]
// Sequence: an invalid input goes from start through the check state to the result
// strobe; otherwise the unit walks years from year 1 (one year per cycle up to the
// target year), then months, at most 12, then emits; the year walk is the longest part.
// Throughput: one word at a time; start is taken in the cycle the result strobes.
// Reset: synchronous active-low i_rst_n returns the controller to idle and clears
// the strobe; the result is shown for one cycle and the receiver cannot stall.
`timescale 1ns / 1ps

module gregorian_date_converter_unit
    import gdc_pkg::*;
#(
    parameter int MAX_YEAR = 9999
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      start,
    input  t_in_word  i_word,
    output logic      busy,
    output t_out_word o_result,
    output logic      o_valid
);

    t_ctrl_cmd  cmd;
    t_dp_status status;

    // controller
    gdc_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (start),
        .i_status (status),
        .o_cmd    (cmd),
        .o_busy   (busy)
    );

    // datapath
    gdc_datapath #(
        .MAX_YEAR (MAX_YEAR)
    ) u_datapath (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_word   (i_word),
        .i_cmd    (cmd),
        .o_status (status),
        .o_result (o_result),
        .o_valid  (o_valid)
    );

`ifndef SYNTHESIS
    // accepted word makes the unit busy
    a_start_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("unit not busy after accepted word");

    // result strobe only once the unit has gone idle
    a_valid_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !busy)
        else $error("result strobe while busy");

    // error result carries zero fields
    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_result.status) |-> (o_result.out_year == 14'd0
            && o_result.out_month == 4'd0 && o_result.out_day == 5'd0
            && o_result.day_of_year == 9'd0))
        else $error("error result with nonzero fields");

    // good result has a real month and day
    a_ok_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_result.status) |-> (o_result.out_month >= 4'd1
            && o_result.out_month <= 4'd12 && o_result.out_day >= 5'd1
            && o_result.day_of_year >= 9'd1))
        else $error("good result out of range");
`endif

endmodule

[src/gdc_ctrl.sv]
// controller state machine for the gregorian date converter
`timescale 1ns / 1ps

module gdc_ctrl
    import gdc_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_start,
    input  t_dp_status i_status,
    output t_ctrl_cmd  o_cmd,
    output logic       o_busy
);

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_CHECK = 2'd1;
    localparam logic [1:0] ST_YEAR  = 2'd2;
    localparam logic [1:0] ST_MONTH = 2'd3;

    logic [1:0] r_state;
    logic [1:0] n_state;

    // next state and datapath commands
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            ST_IDLE: begin
                if (i_start) begin
                    o_cmd.load = 1'b1;
                    n_state    = ST_CHECK;
                end
            end
            ST_CHECK: begin
                if (i_status.in_ok) begin
                    n_state = ST_YEAR;
                end else begin
                    o_cmd.emit = 1'b1;
                    n_state    = ST_IDLE;
                end
            end
            ST_YEAR: begin
                if (i_status.year_done) begin
                    o_cmd.month_enter = 1'b1;
                    n_state           = ST_MONTH;
                end else begin
                    o_cmd.year_step = 1'b1;
                end
            end
            ST_MONTH: begin
                if (i_status.month_done) begin
                    o_cmd.emit = 1'b1;
                    n_state    = ST_IDLE;
                end else begin
                    o_cmd.month_step = 1'b1;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_busy = (r_state != ST_IDLE);

endmodule

[src/gdc_datapath.sv]
// datapath for the gregorian date converter: year walk, month walk, result register
`timescale 1ns / 1ps

module gdc_datapath
    import gdc_pkg::*;
#(
    parameter int MAX_YEAR = 9999
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_in_word   i_word,
    input  t_ctrl_cmd  i_cmd,
    output t_dp_status o_status,
    output t_out_word  o_result,
    output logic       o_valid
);

    localparam logic [YEAR_W-1:0] MaxYear = YEAR_W'(MAX_YEAR);
    localparam int unsigned DaysMax =
        365 * MAX_YEAR + MAX_YEAR / 4 - MAX_YEAR / 100 + MAX_YEAR / 400;
    localparam logic [31:0] DaysMaxV = 32'(DaysMax);

    // captured request
    logic [1:0]        r_cmd;
    logic [13:0]       r_yr;
    logic [3:0]        r_mo;
    logic [4:0]        r_dy;
    logic              r_in_ok;
    // walk state
    logic [YEAR_W-1:0] r_year;
    logic [1:0]        r_mod4;
    logic [6:0]        r_mod100;
    logic [8:0]        r_mod400;
    logic [21:0]       r_rem;
    logic [3:0]        r_mon;
    logic [8:0]        r_doy;
    // result
    t_out_word         r_result;
    logic              r_valid;

    logic              leap;
    logic [8:0]        ylen;
    logic [4:0]        mlen;
    logic              in_ok;
    logic              year_ok;
    logic              final_ok;
    logic [21:0]       rem_inc;

    // leap year from the running residues
    assign leap = ((r_mod4 == 2'd0) && (r_mod100 != 7'd0)) || (r_mod400 == 9'd0);
    assign ylen = leap ? DAYS_LEAP : DAYS_COMMON;
    assign mlen = month_len(r_mon, leap);
    assign rem_inc = r_rem + 22'd1;

    // input range check at load
    assign year_ok = ({2'b00, i_word.year} >= YEAR_W'(1))
                  && ({2'b00, i_word.year} <= MaxYear);
    always_comb begin
        case (i_word.command)
            CMD_DATE_TO_DOY: begin
                in_ok = year_ok && (i_word.month >= 4'd1) && (i_word.month <= 4'd12);
            end
            CMD_ORD_TO_DATE: begin
                in_ok = year_ok && (i_word.day_number >= 22'd1)
                     && (i_word.day_number <= 22'(DAYS_LEAP));
            end
            CMD_SER_TO_DATE: begin
                in_ok = (i_word.day_number >= 22'd1)
                     && ({10'd0, i_word.day_number} <= DaysMaxV);
            end
            default: begin
                in_ok = 1'b0;
            end
        endcase
    end

    // walk termination flags
    always_comb begin
        o_status.in_ok = r_in_ok;
        if (r_cmd == CMD_SER_TO_DATE) begin
            o_status.year_done  = (r_rem < 22'(ylen));
        end else begin
            o_status.year_done  = (r_year == {2'b00, r_yr});
        end
        if (r_cmd == CMD_DATE_TO_DOY) begin
            o_status.month_done = (r_mon == r_mo);
        end else begin
            o_status.month_done = (r_mon == 4'd12) || (r_rem <= 22'(mlen));
        end
    end

    // final length checks that need the leap flag
    always_comb begin
        case (r_cmd)
            CMD_DATE_TO_DOY: final_ok = (r_dy >= 5'd1) && (r_dy <= mlen);
            CMD_ORD_TO_DATE: final_ok = (r_doy <= ylen);
            default:         final_ok = 1'b1;
        endcase
    end

    // request capture and walk registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_cmd    <= i_word.command;
            r_yr     <= i_word.year;
            r_mo     <= i_word.month;
            r_dy     <= i_word.day;
            r_in_ok  <= in_ok;
            r_year   <= YEAR_W'(1);
            r_mod4   <= 2'd1;
            r_mod100 <= 7'd1;
            r_mod400 <= 9'd1;
            if (i_word.command == CMD_SER_TO_DATE) begin
                r_rem <= i_word.day_number - 22'd1;
            end else begin
                r_rem <= i_word.day_number;
            end
        end else if (i_cmd.year_step) begin
            r_year   <= r_year + YEAR_W'(1);
            r_mod4   <= r_mod4 + 2'd1;
            r_mod100 <= (r_mod100 == 7'd99)  ? 7'd0 : r_mod100 + 7'd1;
            r_mod400 <= (r_mod400 == 9'd399) ? 9'd0 : r_mod400 + 9'd1;
            if (r_cmd == CMD_SER_TO_DATE) begin
                r_rem <= r_rem - 22'(ylen);
            end
        end else if (i_cmd.month_enter) begin
            r_mon <= 4'd1;
            case (r_cmd)
                CMD_DATE_TO_DOY: begin
                    r_rem <= '0;
                end
                CMD_SER_TO_DATE: begin
                    r_rem <= rem_inc;
                    r_doy <= rem_inc[8:0];
                end
                default: begin
                    r_doy <= r_rem[8:0];
                end
            endcase
        end else if (i_cmd.month_step) begin
            r_mon <= r_mon + 4'd1;
            if (r_cmd == CMD_DATE_TO_DOY) begin
                r_rem <= r_rem + 22'(mlen);
            end else begin
                r_rem <= r_rem - 22'(mlen);
            end
        end
    end

    // result word
    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            if (r_in_ok && final_ok) begin
                r_result.out_year  <= r_year[13:0];
                r_result.out_month <= r_mon;
                r_result.status    <= 1'b0;
                if (r_cmd == CMD_DATE_TO_DOY) begin
                    r_result.out_day     <= r_dy;
                    r_result.day_of_year <= r_rem[8:0] + 9'(r_dy);
                end else begin
                    r_result.out_day     <= r_rem[4:0];
                    r_result.day_of_year <= r_doy;
                end
            end else begin
                r_result.out_year    <= '0;
                r_result.out_month   <= '0;
                r_result.out_day     <= '0;
                r_result.day_of_year <= '0;
                r_result.status      <= 1'b1;
            end
        end
    end

    // one-cycle result strobe
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_cmd.emit;
        end
    end

    assign o_result = r_result;
    assign o_valid  = r_valid;

endmodule

[tb/tb_gregorian_date_converter_unit.sv]
// self-checking testbench for the gregorian date converter unit
`timescale 1ns / 1ps

module tb_gregorian_date_converter_unit;
    import gdc_pkg::*;

    localparam int unsigned MAX_YEAR       = 9999;
    localparam logic [1:0]  CMD_UNUSED     = 2'd3;
    localparam int unsigned IDLE_PCT       = 21;
    localparam int unsigned RANDOM_WORDS   = 75;
    localparam int unsigned REPORT_LIMIT   = 10;
    localparam int unsigned DRAIN_CYCLES   = 20;
    // longest correct word walks every year up to MAX_YEAR, allow a wide margin
    localparam int unsigned WATCHDOG_LIMIT = 40000;

    // calendar predictor and queue of predicted result words
    class date_scoreboard;
        t_out_word   expected_q[$];
        int unsigned mismatch_count;

        function new();
            mismatch_count = 0;
        endfunction

        function bit leap_year(input int unsigned y);
            return ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
        endfunction

        function int unsigned days_in_month(input int unsigned y, input int unsigned m);
            case (m)
                2:          return leap_year(y) ? 29 : 28;
                4, 6, 9, 11: return 30;
                default:    return 31;
            endcase
        endfunction

        function int unsigned days_in_year(input int unsigned y);
            return leap_year(y) ? 366 : 365;
        endfunction

        // days from the first day of year 1 through the last day of year y
        function int unsigned days_through_year(input int unsigned y);
            return 365 * y + y / 4 - y / 100 + y / 400;
        endfunction

        function void ordinal_to_month_day(input int unsigned y, input int unsigned ord,
                                           output int unsigned m, output int unsigned d);
            int unsigned mm;
            int unsigned rest;
            mm   = 1;
            rest = ord;
            while (mm < 12 && rest > days_in_month(y, mm)) begin
                rest = rest - days_in_month(y, mm);
                mm++;
            end
            m = mm;
            d = rest;
        endfunction

        function t_out_word convert_date(input t_in_word w);
            t_out_word   r;
            int unsigned yr, mo, dy, dn;
            int unsigned ry, rm, rd, rdoy, acc, rem;
            int unsigned n400, n100, n4, n1;
            bit          ok;
            yr   = 32'(w.year);
            mo   = 32'(w.month);
            dy   = 32'(w.day);
            dn   = 32'(w.day_number);
            ry   = 0;
            rm   = 0;
            rd   = 0;
            rdoy = 0;
            ok   = 1'b0;
            case (w.command)
                CMD_DATE_TO_DOY: begin
                    if (yr >= 1 && yr <= MAX_YEAR && mo >= 1 && mo <= 12 &&
                        dy >= 1 && dy <= days_in_month(yr, mo)) begin
                        acc = 0;
                        for (int unsigned i = 1; i < mo; i++)
                            acc = acc + days_in_month(yr, i);
                        ry   = yr;
                        rm   = mo;
                        rd   = dy;
                        rdoy = acc + dy;
                        ok   = 1'b1;
                    end
                end
                CMD_ORD_TO_DATE: begin
                    if (yr >= 1 && yr <= MAX_YEAR && dn >= 1 && dn <= days_in_year(yr)) begin
                        ry   = yr;
                        rdoy = dn;
                        ordinal_to_month_day(yr, dn, rm, rd);
                        ok   = 1'b1;
                    end
                end
                CMD_SER_TO_DATE: begin
                    if (dn >= 1 && dn <= days_through_year(MAX_YEAR)) begin
                        // split into 400, 100, 4 and 1 year cycles, clamping the last ones
                        rem  = dn - 1;
                        n400 = rem / 146097;
                        rem  = rem % 146097;
                        n100 = rem / 36524;
                        if (n100 > 3)
                            n100 = 3;
                        rem  = rem - n100 * 36524;
                        n4   = rem / 1461;
                        rem  = rem % 1461;
                        n1   = rem / 365;
                        if (n1 > 3)
                            n1 = 3;
                        rem  = rem - n1 * 365;
                        ry   = n400 * 400 + n100 * 100 + n4 * 4 + n1 + 1;
                        rdoy = rem + 1;
                        ordinal_to_month_day(ry, rdoy, rm, rd);
                        ok   = 1'b1;
                    end
                end
                default: ok = 1'b0;
            endcase
            r = '0;
            if (ok) begin
                r.out_year    = 14'(ry);
                r.out_month   = 4'(rm);
                r.out_day     = 5'(rd);
                r.day_of_year = 9'(rdoy);
            end else begin
                r.status = 1'b1;
            end
            return r;
        endfunction

        function void note_word(input t_in_word w);
            expected_q.push_back(convert_date(w));
        endfunction

        function void check_result(input t_out_word got);
            t_out_word want;
            if (expected_q.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= REPORT_LIMIT)
                    $display("%0t: result word with none expected: %p", $realtime, got);
                return;
            end
            want = expected_q.pop_front();
            if (got.out_year !== want.out_year || got.out_month !== want.out_month ||
                got.out_day !== want.out_day || got.day_of_year !== want.day_of_year ||
                got.status !== want.status) begin
                mismatch_count++;
                if (mismatch_count <= REPORT_LIMIT)
                    $display("%0t: mismatch expected %p actual %p", $realtime, want, got);
            end
        endfunction

        function int unsigned pending();
            return expected_q.size();
        endfunction
    endclass

    logic           i_clk;
    logic           i_rst_n;
    logic           start;
    t_in_word       i_word;
    logic           busy;
    t_out_word      o_result;
    logic           o_valid;

    date_scoreboard sb;
    int unsigned    stall_cycles;

    gregorian_date_converter_unit #(
        .MAX_YEAR(MAX_YEAR)
    ) u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .i_word  (i_word),
        .busy    (busy),
        .o_result(o_result),
        .o_valid (o_valid)
    );

    // clock
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // word acceptance, result check and watchdog
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (start && !busy)
                sb.note_word(i_word);
            if (o_valid)
                sb.check_result(o_result);
            if ((start && !busy) || o_valid)
                stall_cycles = 0;
            else
                stall_cycles = stall_cycles + 1;
            if (stall_cycles >= WATCHDOG_LIMIT) begin
                $display("watchdog expired at %0t", $realtime);
                $display("Testbench completed WITH ERRORS");
                $finish;
            end
        end
    end

    function automatic t_in_word date_word(input logic [1:0] cmd, input int unsigned y,
                                           input int unsigned m, input int unsigned d,
                                           input int unsigned dn);
        t_in_word w;
        w.command    = cmd;
        w.year       = 14'(y);
        w.month      = 4'(m);
        w.day        = 5'(d);
        w.day_number = 22'(dn);
        return w;
    endfunction

    // mostly short year walks, a few reach toward the top year
    function automatic int unsigned pick_year();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return $urandom_range(1, 450);
        else if (r < 90)
            return $urandom_range(1, 2400);
        else
            return $urandom_range(1, MAX_YEAR);
    endfunction

    // present one word, optionally after random idle cycles, until it is taken
    task automatic send_word(input t_in_word w, input bit idle_ok);
        while (idle_ok && $urandom_range(0, 99) < IDLE_PCT) begin
            @(negedge i_clk);
            start <= 1'b0;
            @(posedge i_clk);
        end
        @(negedge i_clk);
        start  <= 1'b1;
        i_word <= w;
        do @(posedge i_clk); while (busy);
    endtask

    task automatic wait_for_results();
        while (sb.pending() != 0)
            @(posedge i_clk);
    endtask

    // stimulus
    initial begin
        t_in_word    directed_q[$];
        t_in_word    w;
        int unsigned y, m, kind, last_serial;
        bit          idle_ok;

        sb           = new();
        stall_cycles = 0;
        i_rst_n      = 1'b0;
        start        = 1'b0;
        i_word       = '0;
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        last_serial = sb.days_through_year(MAX_YEAR);

        // date to day of year: extremes, leap centuries and each bad field
        directed_q.push_back(date_word(CMD_DATE_TO_DOY, 1, 1, 1, 0));
        directed_q.push_back(date_word(CMD_DATE_TO_DOY, MAX_YEAR, 12, 31, 0));
        directed_q.push_back(date_word(CMD_DATE_TO_DOY, 2000, 2, 29, 0));
        directed_q.push_back(date_word(CMD_DATE_TO_DOY, 1900, 2, 29, 0));
        directed_q.push_back(date_word(CMD_DATE_TO_DOY, 2024, 12, 31, 0));
        directed_q.push_back(date_word(CMD_DATE_TO_DOY, 0, 5, 5, 0));
        directed_q.push_back(date_word(CMD_DATE_TO_DOY, MAX_YEAR + 1, 1, 1, 0));
        directed_q.push_back(date_word(CMD_DATE_TO_DOY, 16383, 15, 31, 4194303));
        directed_q.push_back(date_word(CMD_DATE_TO_DOY, 7, 0, 1, 0));
        directed_q.push_back(date_word(CMD_DATE_TO_DOY, 7, 13, 1, 0));
        directed_q.push_back(date_word(CMD_DATE_TO_DOY, 7, 4, 31, 0));
        directed_q.push_back(date_word(CMD_DATE_TO_DOY, 7, 4, 0, 0));
        // ordinal to date: last day of a leap year, a leap day, bad ordinals and a bad year
        directed_q.push_back(date_word(CMD_ORD_TO_DATE, 2024, 0, 0, 366));
        directed_q.push_back(date_word(CMD_ORD_TO_DATE, 2023, 0, 0, 366));
        directed_q.push_back(date_word(CMD_ORD_TO_DATE, 400, 0, 0, 60));
        directed_q.push_back(date_word(CMD_ORD_TO_DATE, 5, 0, 0, 0));
        directed_q.push_back(date_word(CMD_ORD_TO_DATE, 0, 0, 0, 1));
        // serial to date: first and last day, out of range, cycle ends
        directed_q.push_back(date_word(CMD_SER_TO_DATE, 0, 0, 0, 1));
        directed_q.push_back(date_word(CMD_SER_TO_DATE, 0, 0, 0, last_serial));
        directed_q.push_back(date_word(CMD_SER_TO_DATE, 0, 0, 0, last_serial + 1));
        directed_q.push_back(date_word(CMD_SER_TO_DATE, 0, 0, 0, 0));
        directed_q.push_back(date_word(CMD_SER_TO_DATE, 0, 0, 0, 146097));
        directed_q.push_back(date_word(CMD_SER_TO_DATE, 0, 0, 0, 36524));
        directed_q.push_back(date_word(CMD_SER_TO_DATE, 0, 0, 0, 1461));
        // unused command code
        directed_q.push_back(date_word(CMD_UNUSED, 2000, 2, 2, 100));

        foreach (directed_q[k])
            send_word(directed_q[k], 1'b1);

        // hold off until the block has answered everything
        @(negedge i_clk);
        start <= 1'b0;
        wait_for_results();

        // random words, a stretch in the middle with no idle cycles
        for (int unsigned n = 0; n < RANDOM_WORDS; n++) begin
            idle_ok = !(n >= 30 && n < 60);
            kind    = $urandom_range(0, 99);
            if (kind < 75) begin
                y = pick_year();
                case ($urandom_range(0, 2))
                    0: begin
                        m = $urandom_range(1, 12);
                        w = date_word(CMD_DATE_TO_DOY, y, m,
                                      $urandom_range(1, sb.days_in_month(y, m)), 0);
                    end
                    1: w = date_word(CMD_ORD_TO_DATE, y, 0, 0,
                                     $urandom_range(1, sb.days_in_year(y)));
                    default: w = date_word(CMD_SER_TO_DATE, 0, 0, 0,
                                           sb.days_through_year(y - 1) +
                                           $urandom_range(1, sb.days_in_year(y)));
                endcase
                // content of the unused month and day fields, and of the serial year, is random
                if (w.command != CMD_DATE_TO_DOY) begin
                    w.month = 4'($urandom_range(0, 15));
                    w.day   = 5'($urandom_range(0, 31));
                end
                if (w.command == CMD_SER_TO_DATE)
                    w.year = 14'($urandom_range(0, 16383));
            end else begin
                // noise over the full range of every field
                w = date_word(2'($urandom_range(0, 3)), $urandom_range(0, 16383),
                              $urandom_range(0, 15), $urandom_range(0, 31),
                              $urandom_range(0, 4194303));
            end
            send_word(w, idle_ok);
        end

        // drain and report
        @(negedge i_clk);
        start <= 1'b0;
        wait_for_results();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (sb.mismatch_count == 0 && sb.pending() == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
